FILE: hdl/pwe_pkg.sv
// Shared types, constants and helper functions of the pointer wheel event encoder.
package pwe_pkg;

	localparam int MAX_TICKS   = 16;
	localparam int NOTCH_UNITS = 120;

	localparam int COORD_W = 16;
	localparam int DELTA_W = 16;
	localparam int MASK_W  = 8;
	localparam int BTN_W   = 4;
	localparam int SUM_W   = DELTA_W + 1;
	localparam int MAG_W   = DELTA_W;
	localparam int REM_W   = $clog2(NOTCH_UNITS + 1) + 1;
	localparam int TICK_W  = $clog2(MAX_TICKS + 1);

	localparam int RECIP_SHIFT = MAG_W + $clog2(NOTCH_UNITS);
	localparam int RECIP_W     = MAG_W + 1;
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MULT =
		RECIP_W'((2 ** RECIP_SHIFT + NOTCH_UNITS - 1) / NOTCH_UNITS);

	localparam logic signed [REM_W-1:0] REM_LIMIT = REM_W'(NOTCH_UNITS);

	localparam logic [MASK_W-1:0] BTN_LEFT     = 8'h01;
	localparam logic [MASK_W-1:0] BTN_MIDDLE   = 8'h02;
	localparam logic [MASK_W-1:0] BTN_RIGHT    = 8'h04;
	localparam logic [MASK_W-1:0] BTN_EXTRA    = 8'h80;
	localparam logic [MASK_W-1:0] WHEEL_UP     = 8'h08;
	localparam logic [MASK_W-1:0] WHEEL_DOWN   = 8'h10;
	localparam logic [MASK_W-1:0] WHEEL_POS_H  = 8'h20;
	localparam logic [MASK_W-1:0] WHEEL_NEG_H  = 8'h40;
	localparam logic [MASK_W-1:0] WHEEL_BITS   = 8'h78;

	typedef enum logic [1:0] {
		KIND_MOVE   = 2'd0,
		KIND_BUTTON = 2'd1,
		KIND_WHEEL  = 2'd2
	} pwe_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_V,
		ST_DIV_H,
		ST_EMIT
	} pwe_state_t;

	typedef struct packed {
		pwe_kind_t                  kind;
		logic [COORD_W-1:0]         pos_x;
		logic [COORD_W-1:0]         pos_y;
		logic                       pressed;
		logic [BTN_W-1:0]           buttons;
		logic signed [DELTA_W-1:0]  delta_x;
		logic signed [DELTA_W-1:0]  delta_y;
	} pwe_cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] event_x;
		logic [COORD_W-1:0] event_y;
		logic [MASK_W-1:0]  event_mask;
		logic               last;
	} pwe_evt_t;

	typedef struct packed {
		logic [MAG_W-1:0] quot;
		logic [REM_W-1:0] rem;
	} pwe_div_res_t;

	function automatic logic [MASK_W-1:0] button_bits(logic [BTN_W-1:0] b);
		logic [MASK_W-1:0] bits;
		bits = '0;
		if (b[0]) bits = bits | BTN_LEFT;
		if (b[1]) bits = bits | BTN_MIDDLE;
		if (b[2]) bits = bits | BTN_RIGHT;
		if (b[3]) bits = bits | BTN_EXTRA;
		return bits;
	endfunction

	function automatic logic signed [SUM_W-1:0] wheel_sum(logic signed [DELTA_W-1:0] delta,
		logic signed [REM_W-1:0] rem);
		logic signed [SUM_W-1:0] acc;
		acc = (delta[DELTA_W-1] == rem[REM_W-1]) ? SUM_W'(rem) : '0;
		return SUM_W'(delta) + acc;
	endfunction

	function automatic logic [MAG_W-1:0] sum_mag(logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] neg_s;
		neg_s = -s;
		return s[SUM_W-1] ? neg_s[MAG_W-1:0] : s[MAG_W-1:0];
	endfunction

	function automatic logic [TICK_W-1:0] clamp_ticks(logic [MAG_W-1:0] q);
		return (q > MAG_W'(MAX_TICKS)) ? TICK_W'(MAX_TICKS) : q[TICK_W-1:0];
	endfunction

	function automatic logic signed [REM_W-1:0] signed_rem(logic [REM_W-1:0] r, logic neg);
		return neg ? -$signed(r) : $signed(r);
	endfunction

endpackage

FILE: hdl/pwe_if.sv
// Request and event channel interfaces of the pointer wheel event encoder.
interface pwe_cmd_if;
	logic              valid;
	logic              ready;
	pwe_pkg::pwe_cmd_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pwe_evt_if;
	logic              valid;
	logic              ready;
	pwe_pkg::pwe_evt_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/pointer_wheel_event_encoder_core.sv
// Top level of the pointer wheel event encoder: sequencer, button and wheel state, event output.
// A move or button request yields a single event, shown in the cycle after the request is taken.
// A wheel request runs the vertical and then the horizontal wheel sum through one shared
// divider (reciprocal multiply, remainder, handoff), and the first event is shown once the
// horizontal pass is done; each whole tick then gives a press and a release event at one
// per cycle while evt.ready stays high, up to 64 events in all. The block takes one request
// at a time: ready rises again once the last event of the request has been taken, or once
// the horizontal pass ends for a wheel request that yields no whole tick. A request of
// unused kind is taken and dropped with no event.
module pointer_wheel_event_encoder_core (
	input  logic            clk,
	input  logic            arst_n,
	pwe_cmd_if.sink         cmd,
	pwe_evt_if.source       evt
);

	pwe_pkg::pwe_state_t state_q, state_d;

	logic [pwe_pkg::COORD_W-1:0]        x_q, y_q;
	logic signed [pwe_pkg::DELTA_W-1:0] dx_q;
	logic [pwe_pkg::MASK_W-1:0]         held_q;
	logic signed [pwe_pkg::REM_W-1:0]   vrem_q, hrem_q;
	logic                               vneg_q, hneg_q;
	logic [pwe_pkg::TICK_W-1:0]         vtk_q, htk_q, tk_q;
	logic                               axis_q;
	logic                               press_q;
	logic                               single_q;

	logic                               div_start;
	logic [pwe_pkg::MAG_W-1:0]          div_in;
	logic                               div_done;
	pwe_pkg::pwe_div_res_t              div_res;

	logic signed [pwe_pkg::SUM_W-1:0]   sum_v, sum_h;
	logic [pwe_pkg::TICK_W-1:0]         div_ticks;
	logic [pwe_pkg::MASK_W-1:0]         wheel_bit;
	logic                               last;
	logic                               cmd_take, evt_take;

	pwe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.done     (div_done),
		.res      (div_res)
	);

	assign sum_v     = pwe_pkg::wheel_sum(cmd.data.delta_y, vrem_q);
	assign sum_h     = pwe_pkg::wheel_sum(dx_q, hrem_q);
	assign div_ticks = pwe_pkg::clamp_ticks(div_res.quot);
	assign cmd_take  = cmd.valid && cmd.ready;
	assign evt_take  = evt.valid && evt.ready;

	always_comb begin
		if (axis_q) wheel_bit = hneg_q ? pwe_pkg::WHEEL_NEG_H : pwe_pkg::WHEEL_POS_H;
		else        wheel_bit = vneg_q ? pwe_pkg::WHEEL_DOWN : pwe_pkg::WHEEL_UP;
		last = single_q ||
			(!press_q && (tk_q == pwe_pkg::TICK_W'(1)) && (axis_q || (htk_q == '0)));
	end

	assign evt.data.event_x    = x_q;
	assign evt.data.event_y    = y_q;
	assign evt.data.event_mask = press_q ? (held_q | wheel_bit) : held_q;
	assign evt.data.last       = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pwe_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		evt.valid = 1'b0;
		div_start = 1'b0;
		div_in    = '0;
		case (state_q)
			pwe_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					case (cmd.data.kind)
						pwe_pkg::KIND_MOVE, pwe_pkg::KIND_BUTTON: state_d = pwe_pkg::ST_EMIT;
						pwe_pkg::KIND_WHEEL: begin
							state_d   = pwe_pkg::ST_DIV_V;
							div_start = 1'b1;
							div_in    = pwe_pkg::sum_mag(sum_v);
						end
						default: state_d = pwe_pkg::ST_IDLE;
					endcase
				end
			end
			pwe_pkg::ST_DIV_V: begin
				if (div_done) begin
					state_d   = pwe_pkg::ST_DIV_H;
					div_start = 1'b1;
					div_in    = pwe_pkg::sum_mag(sum_h);
				end
			end
			pwe_pkg::ST_DIV_H: begin
				if (div_done) begin
					if ((vtk_q == '0) && (div_ticks == '0)) state_d = pwe_pkg::ST_IDLE;
					else                                    state_d = pwe_pkg::ST_EMIT;
				end
			end
			pwe_pkg::ST_EMIT: begin
				evt.valid = 1'b1;
				if (evt.ready && last) state_d = pwe_pkg::ST_IDLE;
			end
			default: state_d = pwe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			vrem_q   <= '0;
			hrem_q   <= '0;
			vtk_q    <= '0;
			htk_q    <= '0;
			tk_q     <= '0;
			axis_q   <= 1'b0;
			press_q  <= 1'b0;
			single_q <= 1'b0;
			vneg_q   <= 1'b0;
			hneg_q   <= 1'b0;
		end else begin
			case (state_q)
				pwe_pkg::ST_IDLE: begin
					if (cmd_take) begin
						case (cmd.data.kind)
							pwe_pkg::KIND_MOVE: begin
								single_q <= 1'b1;
								press_q  <= 1'b0;
							end
							pwe_pkg::KIND_BUTTON: begin
								single_q <= 1'b1;
								press_q  <= 1'b0;
								if (cmd.data.pressed)
									held_q <= held_q | pwe_pkg::button_bits(cmd.data.buttons);
								else
									held_q <= held_q & ~pwe_pkg::button_bits(cmd.data.buttons);
							end
							pwe_pkg::KIND_WHEEL: vneg_q <= sum_v[pwe_pkg::SUM_W-1];
							default: ;
						endcase
					end
				end
				pwe_pkg::ST_DIV_V: begin
					if (div_done) begin
						vtk_q  <= div_ticks;
						vrem_q <= pwe_pkg::signed_rem(div_res.rem, vneg_q);
						hneg_q <= sum_h[pwe_pkg::SUM_W-1];
					end
				end
				pwe_pkg::ST_DIV_H: begin
					if (div_done) begin
						htk_q    <= div_ticks;
						hrem_q   <= pwe_pkg::signed_rem(div_res.rem, hneg_q);
						single_q <= 1'b0;
						press_q  <= 1'b1;
						if (vtk_q != '0) begin
							axis_q <= 1'b0;
							tk_q   <= vtk_q;
						end else begin
							axis_q <= 1'b1;
							tk_q   <= div_ticks;
						end
					end
				end
				pwe_pkg::ST_EMIT: begin
					if (evt_take && !single_q) begin
						if (press_q) begin
							press_q <= 1'b0;
						end else if (tk_q == pwe_pkg::TICK_W'(1)) begin
							if (!axis_q && (htk_q != '0)) begin
								axis_q  <= 1'b1;
								tk_q    <= htk_q;
								press_q <= 1'b1;
							end
						end else begin
							tk_q    <= tk_q - 1'b1;
							press_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			x_q  <= cmd.data.pos_x;
			y_q  <= cmd.data.pos_y;
			dx_q <= cmd.data.delta_x;
		end
	end

	a_held_no_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q & pwe_pkg::WHEEL_BITS) == '0)
		else $error("wheel bit in held button mask");

	a_vrem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vrem_q < pwe_pkg::REM_LIMIT) && (vrem_q > -pwe_pkg::REM_LIMIT))
		else $error("vertical remainder out of range");

	a_hrem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hrem_q < pwe_pkg::REM_LIMIT) && (hrem_q > -pwe_pkg::REM_LIMIT))
		else $error("horizontal remainder out of range");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ready && evt.valid))
		else $error("request taken while events pending");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_take && last) |=> !evt.valid)
		else $error("event after last");

	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> (tk_q <= pwe_pkg::TICK_W'(pwe_pkg::MAX_TICKS)))
		else $error("tick count above limit");

endmodule

FILE: hdl/pwe_div.sv
// Shared divider by the notch size: reciprocal multiply for the quotient, then the remainder.
module pwe_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pwe_pkg::MAG_W-1:0] dividend,
	output logic                      done,
	output pwe_pkg::pwe_div_res_t     res
);

	logic                        busy1_q;
	logic                        busy2_q;
	logic                        done_q;
	logic [pwe_pkg::MAG_W-1:0]   dd_q;
	logic [pwe_pkg::MAG_W-1:0]   quot_q;
	logic [pwe_pkg::REM_W-1:0]   rem_q;
	logic [pwe_pkg::PROD_W-1:0]  prod;
	logic [pwe_pkg::MAG_W-1:0]   back;
	logic [pwe_pkg::MAG_W-1:0]   diff;

	always_comb begin
		prod = pwe_pkg::PROD_W'(dd_q) * pwe_pkg::PROD_W'(pwe_pkg::RECIP_MULT);
		back = quot_q * pwe_pkg::MAG_W'(pwe_pkg::NOTCH_UNITS);
		diff = dd_q - back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy1_q <= 1'b0;
			busy2_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			busy1_q <= start;
			busy2_q <= busy1_q;
			done_q  <= busy2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) dd_q <= dividend;
		if (busy1_q) quot_q <= pwe_pkg::MAG_W'(prod >> pwe_pkg::RECIP_SHIFT);
		if (busy2_q) rem_q <= diff[pwe_pkg::REM_W-1:0];
	end

	assign done     = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

FILE: dv/pointer_wheel_event_encoder_core_tb.sv
// Testbench of the pointer wheel event encoder: directed and random requests, predicted events.
module pointer_wheel_event_encoder_core_tb;

	localparam logic [1:0] KIND_MOVE   = pwe_pkg::KIND_MOVE;
	localparam logic [1:0] KIND_BUTTON = pwe_pkg::KIND_BUTTON;
	localparam logic [1:0] KIND_WHEEL  = pwe_pkg::KIND_WHEEL;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_REQUESTS = 238;
	localparam int DRAIN_CYCLES = 48;
	localparam int IDLE_PCT = 18;

	class wheel_event_ledger;
		pwe_pkg::pwe_evt_t pending_events[$];
		logic [pwe_pkg::MASK_W-1:0] held_mask;
		int vert_rem;
		int horiz_rem;
		int mismatches;

		function new();
			held_mask = '0;
			vert_rem = 0;
			horiz_rem = 0;
			mismatches = 0;
		endfunction

		function int axis_ticks(input int delta, inout int rem);
			int sum;
			int ticks;
			sum = delta + (((delta < 0) == (rem < 0)) ? rem : 0);
			ticks = sum / pwe_pkg::NOTCH_UNITS;
			rem = sum % pwe_pkg::NOTCH_UNITS;
			if (ticks > pwe_pkg::MAX_TICKS) ticks = pwe_pkg::MAX_TICKS;
			if (ticks < -pwe_pkg::MAX_TICKS) ticks = -pwe_pkg::MAX_TICKS;
			return ticks;
		endfunction

		function void push_event(pwe_pkg::pwe_cmd_t c, logic [pwe_pkg::MASK_W-1:0] mask);
			pwe_pkg::pwe_evt_t e;
			e.event_x = c.pos_x;
			e.event_y = c.pos_y;
			e.event_mask = mask;
			e.last = 1'b0;
			pending_events.push_back(e);
		endfunction

		function void push_ticks(pwe_pkg::pwe_cmd_t c, int ticks,
			logic [pwe_pkg::MASK_W-1:0] pos_bit, logic [pwe_pkg::MASK_W-1:0] neg_bit);
			int n;
			logic [pwe_pkg::MASK_W-1:0] wheel_bit;
			n = (ticks < 0) ? -ticks : ticks;
			wheel_bit = (ticks < 0) ? neg_bit : pos_bit;
			for (int i = 0; i < n; i++) begin
				push_event(c, wheel_bit | held_mask);
				push_event(c, held_mask);
			end
		endfunction

		function void take_request(pwe_pkg::pwe_cmd_t c);
			int before_count;
			int vt;
			int ht;
			logic [pwe_pkg::MASK_W-1:0] bits;
			pwe_pkg::pwe_evt_t e;
			before_count = pending_events.size();
			case (c.kind)
				pwe_pkg::KIND_MOVE, pwe_pkg::KIND_BUTTON: begin
					if (c.kind == pwe_pkg::KIND_BUTTON) begin
						bits = {c.buttons[3], 4'b0000, c.buttons[2:0]};
						held_mask = c.pressed ? (held_mask | bits) : (held_mask & ~bits);
					end
					push_event(c, held_mask);
				end
				pwe_pkg::KIND_WHEEL: begin
					vt = axis_ticks(int'($signed(c.delta_y)), vert_rem);
					ht = axis_ticks(int'($signed(c.delta_x)), horiz_rem);
					push_ticks(c, vt, pwe_pkg::WHEEL_UP, pwe_pkg::WHEEL_DOWN);
					push_ticks(c, ht, pwe_pkg::WHEEL_POS_H, pwe_pkg::WHEEL_NEG_H);
				end
				default: ;
			endcase
			// mark the final event of this request
			if (pending_events.size() > before_count) begin
				e = pending_events.pop_back();
				e.last = 1'b1;
				pending_events.push_back(e);
			end
		endfunction

		function void match_event(pwe_pkg::pwe_evt_t got);
			pwe_pkg::pwe_evt_t want;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event x=%h y=%h mask=%h last=%b",
						got.event_x, got.event_y, got.event_mask, got.last);
				return;
			end
			want = pending_events.pop_front();
			if (got.event_x !== want.event_x || got.event_y !== want.event_y ||
				got.event_mask !== want.event_mask || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch exp x=%h y=%h mask=%h last=%b got x=%h y=%h mask=%h last=%b",
						want.event_x, want.event_y, want.event_mask, want.last,
						got.event_x, got.event_y, got.event_mask, got.last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic no_gaps = 1'b0;
	int cycle_count = 0;

	pwe_cmd_if cmd_if();
	pwe_evt_if evt_if();

	wheel_event_ledger ledger = new();

	pointer_wheel_event_encoder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.evt    (evt_if)
	);

	always #6 clk = ~clk;

	initial begin
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		evt_if.ready = 1'b0;
	end

	always @(posedge clk) begin
		evt_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && evt_if.valid && evt_if.ready)
			ledger.match_event(evt_if.data);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL pointer_wheel_event_encoder_core");
			$finish;
		end
	end

	function automatic pwe_pkg::pwe_cmd_t make_cmd(logic [1:0] k, int x, int y, logic pr,
		logic [pwe_pkg::BTN_W-1:0] b, int dx, int dy);
		pwe_pkg::pwe_cmd_t c;
		c.kind = pwe_pkg::pwe_kind_t'(k);
		c.pos_x = pwe_pkg::COORD_W'(x);
		c.pos_y = pwe_pkg::COORD_W'(y);
		c.pressed = pr;
		c.buttons = b;
		c.delta_x = pwe_pkg::DELTA_W'(dx);
		c.delta_y = pwe_pkg::DELTA_W'(dy);
		return c;
	endfunction

	function automatic int pick_delta();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0, 1: return 0;
			2, 3, 4: return (int'($urandom_range(6)) - 3) * pwe_pkg::NOTCH_UNITS;
			5, 6: return int'($urandom_range(400)) - 200;
			7: return int'($signed(pwe_pkg::DELTA_W'($urandom)));
			8: return (int'($urandom_range(4)) - 2) * pwe_pkg::NOTCH_UNITS +
				int'($urandom_range(60)) - 30;
			default: return $urandom_range(1) ? 32767 : -32768;
		endcase
	endfunction

	task automatic send_request(pwe_pkg::pwe_cmd_t c);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data <= c;
		do @(posedge clk); while (!cmd_if.ready);
		ledger.take_request(c);
	endtask

	initial begin
		pwe_pkg::pwe_cmd_t c;
		int sent;
		int r;
		logic [1:0] k;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every kind, sign and saturation corners
		send_request(make_cmd(KIND_MOVE, 0, 0, 1'b0, 4'h0, 0, 0));
		send_request(make_cmd(KIND_MOVE, 16'hFFFF, 16'hFFFF, 1'b1, 4'hF, -1, -1));
		send_request(make_cmd(KIND_BUTTON, 16'h1234, 16'h8765, 1'b1, 4'hF, 0, 0));
		send_request(make_cmd(KIND_WHEEL, 16'h00FF, 16'hFF00, 1'b0, 4'h0, 0, 120));
		send_request(make_cmd(KIND_BUTTON, 16'h5555, 16'hAAAA, 1'b0, 4'h5, 0, 0));
		send_request(make_cmd(KIND_BUTTON, 16'hAAAA, 16'h5555, 1'b1, 4'h0, 0, 0));
		send_request(make_cmd(KIND_WHEEL, 1, 2, 1'b1, 4'hA, 120, -120));
		send_request(make_cmd(KIND_WHEEL, 3, 4, 1'b0, 4'h0, -120, 0));
		send_request(make_cmd(KIND_WHEEL, 16'h7FFF, 16'h8000, 1'b0, 4'h0, 32767, 32767));
		send_request(make_cmd(KIND_WHEEL, 16'h8000, 16'h7FFF, 1'b0, 4'h0, -32768, -32768));
		send_request(make_cmd(KIND_WHEEL, 5, 6, 1'b0, 4'h0, -50, -50));
		send_request(make_cmd(KIND_WHEEL, 7, 8, 1'b0, 4'h0, -62, -70));
		send_request(make_cmd(KIND_WHEEL, 9, 10, 1'b0, 4'h0, -60, 60));
		send_request(make_cmd(KIND_WHEEL, 11, 12, 1'b0, 4'h0, 0, 60));
		send_request(make_cmd(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 4'hF, 32767, -32768));
		send_request(make_cmd(KIND_BUTTON, 13, 14, 1'b0, 4'hF, 0, 0));
		send_request(make_cmd(KIND_WHEEL, 15, 16, 1'b1, 4'hF, 0, 0));
		send_request(make_cmd(KIND_WHEEL, 17, 18, 1'b0, 4'h0, -360, 240));
		send_request(make_cmd(KIND_MOVE, 16'h8000, 16'h7FFF, 1'b0, 4'h0, 0, 0));
		send_request(make_cmd(KIND_BUTTON, 19, 20, 1'b1, 4'h8, 0, 0));
		send_request(make_cmd(KIND_WHEEL, 21, 22, 1'b0, 4'h0, 1919, -1920));
		send_request(make_cmd(KIND_WHEEL, 23, 24, 1'b0, 4'h0, 1, -1));

		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			no_gaps <= (sent >= 80 && sent < 140);
			r = $urandom_range(99);
			if (r < 5) k = KIND_UNUSED;
			else if (r < 30) k = KIND_MOVE;
			else if (r < 55) k = KIND_BUTTON;
			else k = KIND_WHEEL;
			c = make_cmd(k, $urandom, $urandom, 1'($urandom), pwe_pkg::BTN_W'($urandom),
				pick_delta(), pick_delta());
			send_request(c);
			sent++;
		end
		cmd_if.valid <= 1'b0;
		no_gaps <= 1'b0;

		while (ledger.pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.mismatches == 0)
			$display("PASS pointer_wheel_event_encoder_core");
		else
			$display("FAIL pointer_wheel_event_encoder_core");
		$finish;
	end

endmodule
